### rtl/wmcf_pkg.sv
// ----------------------------------------------------------------------------
// wmcf_pkg
// Shared types and constants for the window maximum and count filter:
// register indexes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package wmcf_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

  // Register values after reset, before clamping.
  localparam int RST_FRAME_WIDTH  = 1024;
  localparam int RST_FRAME_HEIGHT = 1024;
  localparam int RST_WINDOW_SIZE  = 3;

  // Widths of the result fields that are fixed by the interface.
  localparam int OUT_COUNT_W = 7;
  localparam int OUT_POS_W   = 10;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_WRITE,
    S_HRED,
    S_EMIT
  } wmcf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch a new pixel
    logic rd;      // issue a line store read for the current row offset
    logic cmp;     // fold the returned line store pixel into the column result
    logic wr;      // store the pixel and shift the column results
    logic hstep;   // fold one more column into the window result
    logic emit;    // load the output register
    logic adv;     // advance the frame position
  } wmcf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_more;   // another earlier row takes part in the column
    logic window;    // the current pixel completes a window
    logic h_more;    // another column takes part in the window
    logic out_free;  // the output register can take a result
  } wmcf_status_t;

  // Registers: zero acts as one, oversized values act as the maximum.
  function automatic int clamp_cfg(input int v, input int hi);
    int res;
    if (v == 0) begin
      res = 1;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### rtl/wmcf_ram.sv
// ----------------------------------------------------------------------------
// wmcf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module wmcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/wmcf_ctrl.sv
// ----------------------------------------------------------------------------
// wmcf_ctrl
// Sequencer for one pixel: column scan of the line store, store write,
// scan across the recent columns and hand-off to the output register.
// ----------------------------------------------------------------------------
module wmcf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wmcf_pkg::wmcf_status_t sts,
  output wmcf_pkg::wmcf_cmd_t    cmd
);
  import wmcf_pkg::*;

  wmcf_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = sts.rd_more ? S_CMP : S_WRITE;
      end
      S_CMP: begin
        state_nxt = S_READ;
      end
      S_WRITE: begin
        state_nxt = sts.window ? S_HRED : S_IDLE;
      end
      S_HRED: begin
        if (!sts.h_more) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      S_READ: begin
        cmd.rd = sts.rd_more;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
      end
      S_WRITE: begin
        cmd.wr  = 1'b1;
        cmd.adv = !sts.window;
      end
      S_HRED: begin
        cmd.hstep = sts.h_more;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.adv  = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### rtl/wmcf_dp.sv
// ----------------------------------------------------------------------------
// wmcf_dp
// Datapath: configuration registers, frame position, line store, column
// maxima with tie counts, window reduction and the output register.
// ----------------------------------------------------------------------------
module wmcf_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [wmcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmcf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [PIXEL_BITS-1:0]                in_pixel_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [PIXEL_BITS-1:0]                out_window_max,
  output logic [wmcf_pkg::OUT_COUNT_W-1:0]     out_max_count,
  output logic [wmcf_pkg::OUT_POS_W-1:0]       out_window_row,
  output logic [wmcf_pkg::OUT_POS_W-1:0]       out_window_col,
  output logic                                 out_row_end,
  output logic                                 out_frame_end,
  input  wmcf_pkg::wmcf_cmd_t                  cmd,
  output wmcf_pkg::wmcf_status_t               sts
);
  import wmcf_pkg::*;

  localparam int STORE_ROWS = MAX_WINDOW - 1;
  localparam int SLOT_W     = $clog2(STORE_ROWS + 1);
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = $clog2(MAX_WIDTH + 1);
  localparam int FH_W       = $clog2(MAX_HEIGHT + 1);
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  // Effective (clamped) configuration.
  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [WIN_W-1:0] w_r;

  // Frame position; slot_r is the row index modulo the number of store rows.
  logic [COL_W-1:0]  c_r;
  logic [ROW_W-1:0]  r_r;
  logic [SLOT_W-1:0] slot_r;

  // Per-pixel working registers.
  logic [PIXEL_BITS-1:0] p_r;
  logic [PIXEL_BITS-1:0] cmax_r;
  logic [CNT_W-1:0]      ccnt_r;
  logic [WIN_W-1:0]      k_r;
  logic [PIXEL_BITS-1:0] m_r;
  logic [SUM_W-1:0]      n_r;
  logic [WIN_W-1:0]      j_r;

  // Most recent column results, newest at index zero.
  logic [PIXEL_BITS-1:0] colmax_r [MAX_WINDOW];
  logic [CNT_W-1:0]      colcnt_r [MAX_WINDOW];

  // Output register.
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_max_r;
  logic [OUT_COUNT_W-1:0] out_cnt_r;
  logic [OUT_POS_W-1:0]  out_row_r;
  logic [OUT_POS_W-1:0]  out_col_r;
  logic                  out_row_end_r;
  logic                  out_frame_end_r;

  logic                  cfg_hit;
  logic [SLOT_W-1:0]     rd_slot;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  last_col;
  logic                  last_row;
  logic [PIXEL_BITS-1:0] hcol_max;
  logic [CNT_W-1:0]      hcol_cnt;

  assign cfg_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                 cfg_index == REG_FRAME_HEIGHT ||
                                 cfg_index == REG_WINDOW_SIZE);

  // Configuration registers, clamped when written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_W'(clamp_cfg(RST_FRAME_WIDTH, MAX_WIDTH));
      fh_r <= FH_W'(clamp_cfg(RST_FRAME_HEIGHT, MAX_HEIGHT));
      w_r  <= WIN_W'(clamp_cfg(RST_WINDOW_SIZE, MAX_WINDOW));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= FW_W'(clamp_cfg(int'(cfg_data), MAX_WIDTH));
        REG_FRAME_HEIGHT: fh_r <= FH_W'(clamp_cfg(int'(cfg_data), MAX_HEIGHT));
        REG_WINDOW_SIZE:  w_r  <= WIN_W'(clamp_cfg(int'(cfg_data[3:0]), MAX_WINDOW));
        default: ;
      endcase
    end
  end

  // Position flags of the current pixel.
  assign last_col = (int'(c_r) + 1 >= int'(fw_r));
  assign last_row = (int'(r_r) + 1 >= int'(fh_r));

  // Frame position; a register write starts a new frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r    <= '0;
      r_r    <= '0;
      slot_r <= '0;
    end else if (cfg_hit) begin
      c_r    <= '0;
      r_r    <= '0;
      slot_r <= '0;
    end else if (cmd.adv) begin
      if (last_col) begin
        c_r <= '0;
        if (last_row) begin
          r_r    <= '0;
          slot_r <= '0;
        end else begin
          r_r    <= r_r + 1'b1;
          slot_r <= (int'(slot_r) == STORE_ROWS - 1) ? '0 : slot_r + 1'b1;
        end
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  // Line store addressing: the row k above sits k slots back, wrapping.
  always_comb begin
    if (int'(slot_r) >= int'(k_r)) begin
      rd_slot = SLOT_W'(int'(slot_r) - int'(k_r));
    end else begin
      rd_slot = SLOT_W'(int'(slot_r) + STORE_ROWS - int'(k_r));
    end
    rd_addr = ADDR_W'(int'(rd_slot) * MAX_WIDTH + int'(c_r));
    wr_addr = ADDR_W'(int'(slot_r) * MAX_WIDTH + int'(c_r));
  end

  wmcf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (wr_addr),
    .wr_data (p_r),
    .rd_en   (cmd.rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Column scan: fold earlier rows of this column into max and tie count.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r    <= in_pixel_value;
      cmax_r <= in_pixel_value;
      ccnt_r <= CNT_W'(1);
      k_r    <= WIN_W'(1);
    end else if (cmd.cmp) begin
      if (rd_data > cmax_r) begin
        cmax_r <= rd_data;
        ccnt_r <= CNT_W'(1);
      end else if (rd_data == cmax_r) begin
        ccnt_r <= ccnt_r + 1'b1;
      end
      k_r <= k_r + 1'b1;
    end
  end

  // Column history shift on the store write.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      colmax_r[0] <= cmax_r;
      colcnt_r[0] <= ccnt_r;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        colmax_r[i] <= colmax_r[i-1];
        colcnt_r[i] <= colcnt_r[i-1];
      end
    end
  end

  assign hcol_max = colmax_r[j_r[IDX_W-1:0]];
  assign hcol_cnt = colcnt_r[j_r[IDX_W-1:0]];

  // Window scan across the recent columns, one column a cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      m_r <= cmax_r;
      n_r <= SUM_W'(ccnt_r);
      j_r <= WIN_W'(1);
    end else if (cmd.hstep) begin
      if (hcol_max > m_r) begin
        m_r <= hcol_max;
        n_r <= SUM_W'(hcol_cnt);
      end else if (hcol_max == m_r) begin
        n_r <= n_r + SUM_W'(hcol_cnt);
      end
      j_r <= j_r + 1'b1;
    end
  end

  // Output register: holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_max_r       <= m_r;
      out_cnt_r       <= OUT_COUNT_W'(n_r);
      out_row_r       <= OUT_POS_W'(int'(r_r) + 1 - int'(w_r));
      out_col_r       <= OUT_POS_W'(int'(c_r) + 1 - int'(w_r));
      out_row_end_r   <= last_col;
      out_frame_end_r <= last_col && (int'(r_r) + 1 == int'(fh_r));
    end
  end

  // Status to the controller.
  always_comb begin
    sts.rd_more  = (k_r < w_r) && (int'(r_r) >= int'(k_r));
    sts.window   = (int'(r_r) + 1 >= int'(w_r)) && (int'(c_r) + 1 >= int'(w_r));
    sts.h_more   = (j_r < w_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;
  assign out_max_count  = out_cnt_r;
  assign out_window_row = out_row_r;
  assign out_window_col = out_col_r;
  assign out_row_end    = out_row_end_r;
  assign out_frame_end  = out_frame_end_r;

endmodule

### rtl/window_max_with_count_filter_unit.sv
// ----------------------------------------------------------------------------
// window_max_with_count_filter_unit
// Sliding square-window maximum filter with a count of pixels equal to the max.
// ----------------------------------------------------------------------------
// Per pixel, the column scan reads R = min(row, W-1) earlier rows (W is the
// window size) one at a time through the single read port of the line store;
// a pixel that completes a window then also scans across the recent columns.
// A result waits in the output register while the next pixel is taken.
// Synchronous active-low reset clears control state; the line store holds no
// valid data after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module window_max_with_count_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wmcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [PIXEL_BITS-1:0]            in_pixel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [PIXEL_BITS-1:0]            out_window_max,
  output logic [wmcf_pkg::OUT_COUNT_W-1:0] out_max_count,
  output logic [wmcf_pkg::OUT_POS_W-1:0]   out_window_row,
  output logic [wmcf_pkg::OUT_POS_W-1:0]   out_window_col,
  output logic                             out_row_end,
  output logic                             out_frame_end
);
  import wmcf_pkg::*;

  wmcf_cmd_t    cmd;
  wmcf_status_t sts;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  wmcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  wmcf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max),
    .out_max_count  (out_max_count),
    .out_window_row (out_window_row),
    .out_window_col (out_window_col),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the window maximum and count filter. An internal
// predictor tracks the line rows, column maxima and frame position; each
// accepted pixel transaction may queue one expected window result, which is
// compared field by field with the results the unit produces. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import wmcf_pkg::*;

  localparam int MW = 1024;
  localparam int MH = 1024;
  localparam int MWIN = 8;
  localparam int DRAIN_CYCLES = 48;

  typedef struct packed {
    logic [15:0] wmax;
    logic [6:0]  cnt;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        re;
    logic        fe;
  } win_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_pixel_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           out_window_max;
  logic [OUT_COUNT_W-1:0] out_max_count;
  logic [OUT_POS_W-1:0]  out_window_row;
  logic [OUT_POS_W-1:0]  out_window_col;
  logic                  out_row_end;
  logic                  out_frame_end;

  window_max_with_count_filter_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_window_max(out_window_max), .out_max_count(out_max_count),
    .out_window_row(out_window_row), .out_window_col(out_window_col),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end)
  );

  // Predictor state.
  logic [15:0] row_lines [0:MWIN-2][0:MW-1];
  logic [15:0] col_max [0:MWIN-1];
  int          col_cnt [0:MWIN-1];
  int          cur_col, cur_row;
  logic [10:0] width_reg, height_reg;
  logic [3:0]  win_reg;

  win_result_t expected_windows[$];
  int          err_count;
  int          burst_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Overall limit on run time.
  initial begin
    #60000000;
    $display("window_max_with_count_filter_unit verification failed");
    $finish;
  end

  function automatic int clamp_val(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute the window result, if any, that one accepted pixel completes.
  function automatic void predict_window(input logic [15:0] pix);
    int fw, fh, w, r, c, k, n;
    logic [15:0] cm, m, v;
    int cc;
    win_result_t res;
    fw = clamp_val(width_reg, MW);
    fh = clamp_val(height_reg, MH);
    w = clamp_val(win_reg, MWIN);
    r = (cur_row >= fh) ? 0 : cur_row;
    c = (cur_col >= fw) ? 0 : cur_col;
    cm = pix;
    cc = 1;
    // Fold in the earlier rows of this column.
    for (k = 1; k < w; k++) begin
      if (r >= k) begin
        v = row_lines[(r - k) % (MWIN - 1)][c];
        if (v > cm) begin
          cm = v;
          cc = 1;
        end else if (v == cm) begin
          cc++;
        end
      end
    end
    row_lines[r % (MWIN - 1)][c] = pix;
    for (k = MWIN - 1; k > 0; k--) begin
      col_max[k] = col_max[k-1];
      col_cnt[k] = col_cnt[k-1];
    end
    col_max[0] = cm;
    col_cnt[0] = cc;
    // Combine the most recent columns when a window is complete.
    if (r + 1 >= w && c + 1 >= w) begin
      m = col_max[0];
      n = col_cnt[0];
      for (k = 1; k < w; k++) begin
        if (col_max[k] > m) begin
          m = col_max[k];
          n = col_cnt[k];
        end else if (col_max[k] == m) begin
          n += col_cnt[k];
        end
      end
      res.wmax = m;
      res.cnt = n[6:0];
      res.row = 10'(r + 1 - w);
      res.col = 10'(c + 1 - w);
      res.re = (c + 1 == fw);
      res.fe = (c + 1 == fw) && (r + 1 == fh);
      expected_windows.push_back(res);
    end
    if (c + 1 >= fw) begin
      cur_col = 0;
      cur_row = (r + 1 >= fh) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endfunction

  // Check every accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    win_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_windows.size() == 0) begin
        $error("unexpected result: max %0d count %0d row %0d col %0d",
               out_window_max, out_max_count, out_window_row, out_window_col);
        err_count++;
      end else begin
        exp_res = expected_windows.pop_front();
        if (out_window_max !== exp_res.wmax) begin
          $error("window_max: expected %0d actual %0d", exp_res.wmax, out_window_max);
          err_count++;
        end
        if (out_max_count !== exp_res.cnt) begin
          $error("max_count: expected %0d actual %0d", exp_res.cnt, out_max_count);
          err_count++;
        end
        if (out_window_row !== exp_res.row) begin
          $error("window_row: expected %0d actual %0d", exp_res.row, out_window_row);
          err_count++;
        end
        if (out_window_col !== exp_res.col) begin
          $error("window_col: expected %0d actual %0d", exp_res.col, out_window_col);
          err_count++;
        end
        if (out_row_end !== exp_res.re) begin
          $error("row_end: expected %0d actual %0d", exp_res.re, out_row_end);
          err_count++;
        end
        if (out_frame_end !== exp_res.fe) begin
          $error("frame_end: expected %0d actual %0d", exp_res.fe, out_frame_end);
          err_count++;
        end
      end
    end
  end

  // Receiver stall pattern: phases of no stall, random stall and long stalls.
  int stall_mode, stall_phase, stall_tick;
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_phase <= $urandom_range(20, 200);
      stall_tick <= 0;
    end else begin
      stall_phase <= stall_phase - 1;
      stall_tick <= stall_tick + 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= (stall_tick % 24) < 14;
    endcase
  end

  // Send one pixel transaction, with bursts and gaps on the valid line.
  task automatic send_pixel(input logic [15:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (in_stall);
    predict_window(pix);
    burst_left--;
  endtask

  // Wait until the unit is idle, stopping the sender first.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (expected_windows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register while the unit is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_WINDOW_SIZE:  win_reg = val[3:0];
      default: ;
    endcase
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT || idx == REG_WINDOW_SIZE) begin
      cur_col = 0;
      cur_row = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [10:0] fw, input logic [10:0] fh,
                           input logic [10:0] ws);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_WINDOW_SIZE, ws);
  endtask

  function automatic logic [15:0] rand_pixel(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 3)) * 16'h5555;
    endcase
  endfunction

  // Registers at their reset values: the first row yields no window.
  task automatic test_reset_defaults();
    repeat (6) send_pixel(16'($urandom));
  endtask

  // Small frames with extreme values, ties and the clamped registers.
  task automatic test_directed();
    // Window 2 over a 4x3 frame with ties and full-scale pixels.
    set_frame(11'd4, 11'd3, 11'd2);
    send_pixel(16'hFFFF); send_pixel(16'h0000); send_pixel(16'hFFFF); send_pixel(16'h0001);
    send_pixel(16'hFFFF); send_pixel(16'h0000); send_pixel(16'h0007); send_pixel(16'h0007);
    send_pixel(16'h0000); send_pixel(16'h0000); send_pixel(16'h0007); send_pixel(16'h0007);
    // A zero window acts as one, so every pixel is its own window.
    set_frame(11'd3, 11'd1, 11'd0);
    repeat (3) send_pixel(16'($urandom));
    // Window larger than the frame never produces a result.
    set_frame(11'd3, 11'd3, 11'd5);
    repeat (4) send_pixel(16'($urandom));
    // Zero width and height act as one; oversized window acts as the maximum.
    set_frame(11'd0, 11'd0, 11'h7FF);
    repeat (2) send_pixel(16'($urandom));
  endtask

  // Largest frame sizes: the start of a full-width row and of a
  // full-height single column, and an 8x8 frame with the largest window.
  task automatic test_extreme_sizes();
    set_frame(11'h7FF, 11'd2, 11'd1);
    repeat (200) send_pixel(rand_pixel(0));
    set_frame(11'd1, 11'd1024, 11'h11);
    repeat (40) send_pixel(rand_pixel(2));
    set_frame(11'd8, 11'd8, 11'd8);
    repeat (64) send_pixel(rand_pixel(2));
  endtask

  // Random frame settings, random content and frames that may end part way.
  task automatic test_random_frames();
    int sent, n, mode, fw, fh, ws;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < 360) begin
      fw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) % 40 : $urandom_range(1, 12);
      fh = $urandom_range(0, 9);
      ws = $urandom_range(0, 9);
      set_frame(11'(fw), 11'(fh), {7'($urandom), 4'(ws)});
      n = clamp_val(fw, MW) * clamp_val(fh, MH) * $urandom_range(1, 2)
          + $urandom_range(0, 5);
      mode = $urandom_range(0, 2);
      repeat (n) send_pixel(rand_pixel(mode));
      sent += n;
      if (!paused && sent > 180) begin
        drain_results();
        paused = 1;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_pixel_value = '0;
    out_stall = 1'b0;
    stall_mode = 0;
    stall_phase = 0;
    stall_tick = 0;
    err_count = 0;
    burst_left = 0;
    cur_col = 0;
    cur_row = 0;
    width_reg = 11'(RST_FRAME_WIDTH);
    height_reg = 11'(RST_FRAME_HEIGHT);
    win_reg = 4'(RST_WINDOW_SIZE);
    for (int i = 0; i < MWIN; i++) begin
      col_max[i] = '0;
      col_cnt[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed();
    test_extreme_sizes();
    test_random_frames();

    drain_results();
    if (err_count == 0) begin
      $display("window_max_with_count_filter_unit verification clean");
    end else begin
      $display("window_max_with_count_filter_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wmcf_pkg.sv
rtl/wmcf_ram.sv
rtl/wmcf_ctrl.sv
rtl/wmcf_dp.sv
rtl/window_max_with_count_filter_unit.sv
sim/tb_top.sv
